// ===== design/brf_pkg.sv =====
// brf_pkg: shared constants for the byte ring FIFO with loss statistics.
// Depends on nothing; imported by brf_store and the top level.
`timescale 1ns / 1ps

package brf_pkg;

    localparam int DEPTH_DEF = 256;   // default ring storage depth
    localparam int MAX_BURST = 64;    // longest accepted operation

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 7;
    localparam int MODE_W  = 3;
    localparam int RING_W  = 9;
    localparam int CNT_W   = 32;
    localparam int LEVEL_W = 8;

    localparam logic [RING_W-1:0] RING_RESET = 9'd256;

    // operation codes carried in the input word's user field
    localparam logic [MODE_W-1:0] MODE_WRITE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DROP  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STATS = 3'd4;

    // result status
    localparam logic ST_DONE    = 1'b0;
    localparam logic ST_REFUSED = 1'b1;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'b01,
        FSM_READ = 2'b10
    } fsm_t;

endpackage

// ===== design/byte_ring_fifo_with_loss_stats.sv =====
// byte_ring_fifo_with_loss_stats: top level, control sequencer and output register.
// Depends on brf_pkg and brf_store.
`timescale 1ns / 1ps
//
//  channel   dir  handshake          payload
//  --------  ---  -----------------  -------------------------------------------------
//  s_*       in   s_tvalid/s_tready  tuser: mode; tdata: length, data_in, count_as_loss
//  m_*       out  m_tvalid/m_tready  tuser: status; tlast: last; tdata: result fields
//  cfg_*     in   cfg_wr_en          cfg_wr_data: ring_size (empties the ring)
//
//  Write, drop, stats and refused/zero-length words are finished on acceptance; a write
//  burst streams one byte per cycle while the output register drains.
//  For read/peek of L bytes the store's registered read port delivers one byte per
//  cycle into the output register while m_tready allows, input held off meanwhile.
//  Reset: pointers, counters and burst state cleared, ring_size = 256; no clearing
//  pass, the byte store is only read where it was written.
//  A stalled output register holds its word and blocks new input words.

module byte_ring_fifo_with_loss_stats
    import brf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,    // length[6:0], data_in[14:7], count_as_loss[15]
    input  logic [MODE_W-1:0] s_tuser,    // mode[2:0]

    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [95:0]       m_tdata,    // data_out[7:0], done_count[14:8],
                                          // fill_level[22:15], free_space[30:23],
                                          // total_written[62:31], total_lost[94:63], 0
    output logic              m_tuser,    // status[0]
    output logic              m_tlast,

    input  logic              cfg_wr_en,
    input  logic [RING_W-1:0] cfg_wr_data
);

    localparam int PTR_W = $clog2(DEPTH);
    // slot arithmetic width: holds DEPTH and any ring_size value
    localparam int SW    = (PTR_W + 1 > RING_W) ? PTR_W + 1 : RING_W;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BURST);

    // ---------------------------------------------------------------- helpers
    function automatic logic [PTR_W-1:0] ring_adv(input logic [PTR_W-1:0] p,
                                                  input logic [SW-1:0]    k,
                                                  input logic [SW-1:0]    n);
        logic [SW:0] sum;
        sum = (SW+1)'(p) + (SW+1)'(k);
        if (sum >= (SW+1)'(n))
        begin
            sum = sum - (SW+1)'(n);
        end
        return PTR_W'(sum);
    endfunction

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [LEN_W-1:0] b);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
        return s[CNT_W] ? '1 : s[CNT_W-1:0];
    endfunction

    // ------------------------------------------------------------ input word
    logic [LEN_W-1:0]  in_len;
    logic [BYTE_W-1:0] in_byte;
    logic              in_loss;
    logic [MODE_W-1:0] in_mode;

    assign in_len  = s_tdata[6:0];
    assign in_byte = s_tdata[14:7];
    assign in_loss = s_tdata[15];
    assign in_mode = s_tuser;

    // ------------------------------------------------------------- registers
    fsm_t               state_reg,     state_next;
    logic [RING_W-1:0]  ring_size_reg, ring_size_next;
    logic [PTR_W-1:0]   rp_reg,        rp_next;
    logic [PTR_W-1:0]   wp_reg,        wp_next;
    logic [CNT_W-1:0]   wr_cnt_reg,    wr_cnt_next;
    logic [CNT_W-1:0]   loss_cnt_reg,  loss_cnt_next;
    logic [LEN_W-1:0]   burst_rem_reg, burst_rem_next;
    logic               burst_ok_reg,  burst_ok_next;
    logic [PTR_W-1:0]   rd_addr_reg,   rd_addr_next;
    logic [LEN_W-1:0]   rd_rem_reg,    rd_rem_next;
    logic [LEN_W-1:0]   rd_len_reg,    rd_len_next;
    logic [LEVEL_W-1:0] rd_fill_reg,   rd_fill_next;
    logic [LEVEL_W-1:0] rd_free_reg,   rd_free_next;
    logic               out_valid_reg, out_valid_next;

    // output payload (no reset)
    logic               out_status_reg;
    logic [BYTE_W-1:0]  out_data_reg;
    logic               out_last_reg;
    logic [LEN_W-1:0]   out_cnt_reg;
    logic [LEVEL_W-1:0] out_fill_reg;
    logic [LEVEL_W-1:0] out_free_reg;
    logic [CNT_W-1:0]   out_tw_reg;
    logic [CNT_W-1:0]   out_tl_reg;

    // result being loaded this cycle
    logic               load_out;
    logic               res_status;
    logic [BYTE_W-1:0]  res_data;
    logic               res_last;
    logic [LEN_W-1:0]   res_cnt;
    logic [LEVEL_W-1:0] res_fill;
    logic [LEVEL_W-1:0] res_free;
    logic [CNT_W-1:0]   res_tw;
    logic [CNT_W-1:0]   res_tl;

    // store ports
    logic               mem_we;
    logic               mem_re;
    logic [PTR_W-1:0]   mem_raddr;
    logic [BYTE_W-1:0]  mem_rdata;

    // ------------------------------------------------------ ring occupancy
    logic [SW-1:0] slots;
    logic [SW-1:0] fill;
    logic [SW-1:0] space;
    logic [SW-1:0] len_ext;
    logic          out_free;
    logic          accept;

    always_comb
    begin
        if (ring_size_reg < RING_W'(2))
        begin
            slots = SW'(2);
        end
        else if (SW'(ring_size_reg) > SW'(DEPTH))
        begin
            slots = SW'(DEPTH);
        end
        else
        begin
            slots = SW'(ring_size_reg);
        end
    end

    assign fill    = (wp_reg >= rp_reg) ? SW'(wp_reg) - SW'(rp_reg)
                                        : slots - SW'(rp_reg) + SW'(wp_reg);
    assign space   = slots - SW'(1) - fill;
    assign len_ext = SW'(in_len);

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == FSM_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    // -------------------------------------------------------- next state
    always_comb
    begin
        state_next     = state_reg;
        ring_size_next = ring_size_reg;
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        wr_cnt_next    = wr_cnt_reg;
        loss_cnt_next  = loss_cnt_reg;
        burst_rem_next = burst_rem_reg;
        burst_ok_next  = burst_ok_reg;
        rd_addr_next   = rd_addr_reg;
        rd_rem_next    = rd_rem_reg;
        rd_len_next    = rd_len_reg;
        rd_fill_next   = rd_fill_reg;
        rd_free_next   = rd_free_reg;
        out_valid_next = out_valid_reg && !m_tready;

        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_raddr = rp_reg;

        load_out   = 1'b0;
        res_status = ST_DONE;
        res_data   = '0;
        res_last   = 1'b1;
        res_cnt    = '0;
        res_fill   = fill[LEVEL_W-1:0];
        res_free   = space[LEVEL_W-1:0];
        res_tw     = '0;
        res_tl     = '0;

        if (cfg_wr_en)
        begin
            // new ring size empties the ring, counters kept
            ring_size_next = cfg_wr_data;
            rp_next        = '0;
            wp_next        = '0;
            burst_rem_next = '0;
            burst_ok_next  = 1'b0;
        end
        else
        begin
            unique case (state_reg)
                FSM_IDLE:
                begin
                    if (accept)
                    begin
                        case (in_mode) inside
                            MODE_WRITE:
                            begin
                                if (burst_rem_reg != '0)
                                begin
                                    // body of a burst: no result
                                    burst_rem_next = burst_rem_reg - LEN_W'(1);
                                    if (burst_ok_reg)
                                    begin
                                        mem_we  = 1'b1;
                                        wp_next = ring_adv(wp_reg, SW'(1), slots);
                                    end
                                end
                                else
                                begin
                                    load_out = 1'b1;
                                    if (in_len == '0)
                                    begin
                                        burst_ok_next = 1'b0;
                                    end
                                    else
                                    begin
                                        burst_rem_next = in_len - LEN_W'(1);
                                        if (in_len > MAX_LEN || len_ext > space)
                                        begin
                                            burst_ok_next = 1'b0;
                                            res_status    = ST_REFUSED;
                                        end
                                        else
                                        begin
                                            burst_ok_next = 1'b1;
                                            wr_cnt_next   = sat_add(wr_cnt_reg, in_len);
                                            mem_we        = 1'b1;
                                            wp_next  = ring_adv(wp_reg, SW'(1), slots);
                                            res_cnt  = in_len;
                                            res_fill = LEVEL_W'(fill + SW'(1));
                                            res_free = LEVEL_W'(space - SW'(1));
                                        end
                                    end
                                end
                            end

                            MODE_STATS:
                            begin
                                burst_rem_next = '0;
                                burst_ok_next  = 1'b0;
                                load_out       = 1'b1;
                                res_tw         = wr_cnt_reg;
                                res_tl         = loss_cnt_reg;
                                wr_cnt_next    = '0;
                                loss_cnt_next  = '0;
                            end

                            MODE_READ, MODE_PEEK, MODE_DROP:
                            begin
                                burst_rem_next = '0;
                                burst_ok_next  = 1'b0;
                                if (in_len > MAX_LEN || len_ext > fill)
                                begin
                                    load_out   = 1'b1;
                                    res_status = ST_REFUSED;
                                end
                                else if (in_len == '0)
                                begin
                                    load_out = 1'b1;
                                end
                                else if (in_mode == MODE_DROP)
                                begin
                                    load_out = 1'b1;
                                    rp_next  = ring_adv(rp_reg, len_ext, slots);
                                    if (in_loss)
                                    begin
                                        loss_cnt_next = sat_add(loss_cnt_reg, in_len);
                                    end
                                    res_cnt  = in_len;
                                    res_fill = LEVEL_W'(fill - len_ext);
                                    res_free = LEVEL_W'(space + len_ext);
                                end
                                else
                                begin
                                    // first byte read now, rest streamed in FSM_READ
                                    mem_re       = 1'b1;
                                    mem_raddr    = rp_reg;
                                    rd_addr_next = ring_adv(rp_reg, SW'(1), slots);
                                    rd_rem_next  = in_len;
                                    rd_len_next  = in_len;
                                    if (in_mode == MODE_READ)
                                    begin
                                        rp_next      = ring_adv(rp_reg, len_ext, slots);
                                        rd_fill_next = LEVEL_W'(fill - len_ext);
                                        rd_free_next = LEVEL_W'(space + len_ext);
                                    end
                                    else
                                    begin
                                        rd_fill_next = fill[LEVEL_W-1:0];
                                        rd_free_next = space[LEVEL_W-1:0];
                                    end
                                    state_next = FSM_READ;
                                end
                            end

                            default:
                            begin
                                // unused codes: word consumed, nothing changes
                            end
                        endcase
                    end
                end

                FSM_READ:
                begin
                    if (out_free)
                    begin
                        load_out    = 1'b1;
                        res_data    = mem_rdata;
                        res_last    = (rd_rem_reg == LEN_W'(1));
                        res_cnt     = rd_len_reg;
                        res_fill    = rd_fill_reg;
                        res_free    = rd_free_reg;
                        rd_rem_next = rd_rem_reg - LEN_W'(1);
                        if (rd_rem_reg == LEN_W'(1))
                        begin
                            state_next = FSM_IDLE;
                        end
                        else
                        begin
                            mem_re       = 1'b1;
                            mem_raddr    = rd_addr_reg;
                            rd_addr_next = ring_adv(rd_addr_reg, SW'(1), slots);
                        end
                    end
                end

                default:
                begin
                    state_next = FSM_IDLE;
                end
            endcase
        end

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    // ------------------------------------------------------ control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            ring_size_reg <= RING_RESET;
            rp_reg        <= '0;
            wp_reg        <= '0;
            wr_cnt_reg    <= '0;
            loss_cnt_reg  <= '0;
            burst_rem_reg <= '0;
            burst_ok_reg  <= 1'b0;
            rd_addr_reg   <= '0;
            rd_rem_reg    <= '0;
            rd_len_reg    <= '0;
            rd_fill_reg   <= '0;
            rd_free_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ring_size_reg <= ring_size_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            wr_cnt_reg    <= wr_cnt_next;
            loss_cnt_reg  <= loss_cnt_next;
            burst_rem_reg <= burst_rem_next;
            burst_ok_reg  <= burst_ok_next;
            rd_addr_reg   <= rd_addr_next;
            rd_rem_reg    <= rd_rem_next;
            rd_len_reg    <= rd_len_next;
            rd_fill_reg   <= rd_fill_next;
            rd_free_reg   <= rd_free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------ output payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_status_reg <= res_status;
            out_data_reg   <= res_data;
            out_last_reg   <= res_last;
            out_cnt_reg    <= res_cnt;
            out_fill_reg   <= res_fill;
            out_free_reg   <= res_free;
            out_tw_reg     <= res_tw;
            out_tl_reg     <= res_tl;
        end
    end

    // ------------------------------------------------------ byte store
    brf_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (wp_reg),
        .wr_data (in_byte),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {1'b0, out_tl_reg, out_tw_reg, out_free_reg, out_fill_reg,
                       out_cnt_reg, out_data_reg};

endmodule

// ===== design/brf_store.sv =====
// brf_store: byte storage of the ring, one write and one read port.
// Read data is registered. Depends on brf_pkg.
`timescale 1ns / 1ps

module brf_store
    import brf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [BYTE_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [BYTE_W-1:0]        rd_data
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
